@@ hdl/psg_registers_and_voice_rates_assert.svh @@
// assertion macros shared by the psg register block
// needs clk and rst_n in scope where used
`ifndef PSG_REGISTERS_AND_VOICE_RATES_ASSERT_SVH
`define PSG_REGISTERS_AND_VOICE_RATES_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PSGRV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PSGRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/psgrv_pkg.sv @@
// shared codes, constants and controller/datapath structs for the psg block
// no dependencies
package psgrv_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] PORT_SEL  = 2'd0;
  localparam logic [1:0] PORT_DATA = 2'd2;

  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_ENV_FINE  = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;
  localparam logic [3:0] REG_PORT_A    = 4'd14;
  localparam logic [3:0] REG_PORT_B    = 4'd15;

  localparam int          NUM_VOICES = 3;
  localparam logic [1:0]  LAST_VOICE = 2'd2;
  localparam logic [16:0] TONE_CLOCK = 17'd125000;

  localparam int         STEP_W   = 5;
  // one quotient bit per step
  localparam logic [4:0] DIV_LAST = 5'd16;

  localparam logic [3:0] DECAY_FULL = 4'd15;

  typedef struct packed {
    logic       bus_load;
    logic       div_init;
    logic       div_step;
    logic       voice_emit;
    logic [1:0] voice;
    logic [1:0] init_voice;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ hdl/psg_registers_and_voice_rates.sv @@
// bus access: its word is on the output register the cycle after it is accepted
// tick: three words, one per voice, each after its divider steps; no new access until it ends
// each tone rate is 125000/period from the single shared one-bit-a-cycle divider
// reset (rst_n low, synchronous) clears the register file, select, decay, lines and out_valid
// top level: joins psgrv_ctrl and psgrv_dp, depends on psgrv_pkg
module psg_registers_and_voice_rates (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_port,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_accepted,
  output logic [3:0]  out_line_outputs,
  output logic        out_printer_valid,
  output logic [7:0]  out_printer_byte,
  output logic [1:0]  out_voice_index,
  output logic [16:0] out_voice_rate,
  output logic [3:0]  out_voice_volume,
  output logic        out_voice_noise,
  output logic        out_last
);
  import psgrv_pkg::*;

  cmd_t    cmd;
  status_t sts;

  psgrv_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd)
  );

  psgrv_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_port           (in_port),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_accepted      (out_accepted),
    .out_line_outputs  (out_line_outputs),
    .out_printer_valid (out_printer_valid),
    .out_printer_byte  (out_printer_byte),
    .out_voice_index   (out_voice_index),
    .out_voice_rate    (out_voice_rate),
    .out_voice_volume  (out_voice_volume),
    .out_voice_noise   (out_voice_noise),
    .out_last          (out_last)
  );

endmodule

@@ hdl/psgrv_ctrl.sv @@
// sequencer for the psg block: accepts words and steps the shared divider per voice
// depends on psgrv_pkg and the assertion header
`include "psg_registers_and_voice_rates_assert.svh"

module psgrv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  psgrv_pkg::status_t sts,
  output psgrv_pkg::cmd_t    cmd
);
  import psgrv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          voice_r, voice_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      voice_r <= 2'd0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      voice_r <= voice_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    voice_nxt      = voice_r;
    step_nxt       = step_r;
    cmd            = '0;
    cmd.voice      = voice_r;
    in_ready       = (state_r == S_IDLE) && sts.out_free;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_operation == OP_TICK) begin
            state_nxt      = S_DIV;
            voice_nxt      = 2'd0;
            step_nxt       = '0;
            cmd.div_init   = 1'b1;
            cmd.init_voice = 2'd0;
          end else begin
            cmd.bus_load = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.voice_emit = 1'b1;
          if (voice_r == LAST_VOICE) begin
            state_nxt = S_IDLE;
          end else begin
            voice_nxt      = voice_r + 1'b1;
            cmd.div_init   = 1'b1;
            cmd.init_voice = voice_r + 1'b1;
            step_nxt       = '0;
            state_nxt      = S_DIV;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `PSGRV_ASSERT_NEXT(a_tick_starts_div,
    in_valid && in_ready && in_operation == OP_TICK,
    state_r == S_DIV && voice_r == 2'd0 && step_r == '0,
    "tick did not start the divider on voice 0")
  `PSGRV_ASSERT_NEXT(a_div_ends,
    state_r == S_DIV && step_r == DIV_LAST,
    state_r == S_EMIT,
    "divider did not hand over after its last step")
  `PSGRV_ASSERT_NEXT(a_last_voice_idle,
    state_r == S_EMIT && sts.out_free && voice_r == LAST_VOICE,
    state_r == S_IDLE,
    "sequencer did not return to idle after the last voice")
  `PSGRV_ASSERT_SAME(a_voice_range, 1'b1, voice_r != 2'd3,
    "voice counter out of range")

endmodule

@@ hdl/psgrv_dp.sv @@
// register file, decay levels, line state, shared restoring divider and output word
// depends on psgrv_pkg
module psgrv_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  psgrv_pkg::cmd_t    cmd,
  output psgrv_pkg::status_t sts,
  input  logic [1:0]         in_operation,
  input  logic [1:0]         in_port,
  input  logic [7:0]         in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_read_data,
  output logic               out_accepted,
  output logic [3:0]         out_line_outputs,
  output logic               out_printer_valid,
  output logic [7:0]         out_printer_byte,
  output logic [1:0]         out_voice_index,
  output logic [16:0]        out_voice_rate,
  output logic [3:0]         out_voice_volume,
  output logic               out_voice_noise,
  output logic               out_last
);
  import psgrv_pkg::*;

  logic [7:0]  regs_r  [16];
  logic [7:0]  regs_nxt[16];
  logic [3:0]  sel_r, sel_nxt;
  logic [3:0]  decay_r  [NUM_VOICES];
  logic [3:0]  decay_nxt[NUM_VOICES];
  logic [3:0]  line_r, line_nxt;

  logic [11:0] divisor_r;
  logic [11:0] rem_r;
  logic [16:0] quot_r;
  logic [12:0] trial;
  logic [12:0] diff;

  logic        ov_r, ov_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        acc_r, acc_nxt;
  logic [3:0]  lo_r, lo_nxt;
  logic        pv_r, pv_nxt;
  logic [7:0]  pb_r, pb_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [16:0] rate_r, rate_nxt;
  logic [3:0]  vol_r, vol_nxt;
  logic        nz_r, nz_nxt;
  logic        last_r, last_nxt;

  logic [11:0] period_w[NUM_VOICES];
  logic [4:0]  volreg_w[NUM_VOICES];

  assign period_w[0] = {regs_r[1][3:0], regs_r[0]};
  assign period_w[1] = {regs_r[3][3:0], regs_r[2]};
  assign period_w[2] = {regs_r[5][3:0], regs_r[4]};
  assign volreg_w[0] = regs_r[8][4:0];
  assign volreg_w[1] = regs_r[9][4:0];
  assign volreg_w[2] = regs_r[10][4:0];

  // envelope shapes that keep decaying
  function automatic logic shape_decays(input logic [3:0] shape);
    shape_decays = (shape <= 4'd7) || (shape == 4'd9) || (shape == 4'd13) || (shape == 4'd15);
  endfunction

  assign sts.out_free = !ov_r || out_ready;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quot_r[16]};
  assign diff  = trial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      divisor_r <= period_w[cmd.init_voice];
      rem_r     <= '0;
      quot_r    <= TONE_CLOCK;
    end else if (cmd.div_step) begin
      if (!diff[12]) begin
        rem_r  <= diff[11:0];
        quot_r <= {quot_r[15:0], 1'b1};
      end else begin
        rem_r  <= trial[11:0];
        quot_r <= {quot_r[15:0], 1'b0};
      end
    end
  end

  logic [7:0]  changed;
  logic [11:0] v_period;
  logic [4:0]  v_vol;
  logic        v_tone, v_noise;
  logic [3:0]  v_lvl, v_dec;
  logic [16:0] v_freq;

  always_comb begin
    regs_nxt  = regs_r;
    sel_nxt   = sel_r;
    decay_nxt = decay_r;
    line_nxt  = line_r;
    ov_nxt    = ov_r;
    rd_nxt    = rd_r;
    acc_nxt   = acc_r;
    lo_nxt    = lo_r;
    pv_nxt    = pv_r;
    pb_nxt    = pb_r;
    idx_nxt   = idx_r;
    rate_nxt  = rate_r;
    vol_nxt   = vol_r;
    nz_nxt    = nz_r;
    last_nxt  = last_r;
    changed   = regs_r[sel_r] ^ in_data;
    v_period  = period_w[cmd.voice];
    v_vol     = volreg_w[cmd.voice];
    v_tone    = !regs_r[REG_MIXER][{1'b0, cmd.voice}];
    v_noise   = !regs_r[REG_MIXER][3'd3 + {1'b0, cmd.voice}];
    v_lvl     = decay_r[cmd.voice];
    v_dec     = (regs_r[REG_ENV_FINE] < 8'd8) ? 4'd2 : 4'd1;
    v_freq    = ((!v_tone && !v_noise) || v_vol == 5'd0 || v_period == 12'd0) ? 17'd0 : quot_r;

    if (cmd.bus_load) begin
      ov_nxt   = 1'b1;
      rd_nxt   = 8'd0;
      acc_nxt  = 1'b0;
      pv_nxt   = 1'b0;
      pb_nxt   = 8'd0;
      idx_nxt  = 2'd0;
      rate_nxt = 17'd0;
      vol_nxt  = 4'd0;
      nz_nxt   = 1'b0;
      last_nxt = 1'b1;
      case (in_operation)
        OP_WRITE: begin
          case (in_port)
            PORT_SEL: begin
              sel_nxt = in_data[3:0];
              acc_nxt = 1'b1;
            end
            PORT_DATA: begin
              acc_nxt        = 1'b1;
              regs_nxt[sel_r] = in_data;
              if (sel_r == REG_ENV_SHAPE) begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                  decay_nxt[v] = DECAY_FULL;
                end
              end
              if (changed != 8'd0) begin
                if (sel_r == REG_PORT_A) begin
                  // strobe goes out on a falling bit 5
                  if (changed[5] && !in_data[5]) begin
                    pv_nxt = 1'b1;
                    pb_nxt = regs_r[REG_PORT_B];
                  end
                  line_nxt = {in_data[4], in_data[3], ~in_data[2], ~in_data[0]};
                end else if (sel_r == REG_MIXER) begin
                  for (int v = 0; v < NUM_VOICES; v++) begin
                    if (changed[v] && !in_data[v]) begin
                      decay_nxt[v] = DECAY_FULL;
                    end
                  end
                end
              end
            end
            default: begin
              acc_nxt = 1'b0;
            end
          endcase
        end
        OP_READ: begin
          rd_nxt  = regs_r[sel_r];
          acc_nxt = 1'b1;
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
      lo_nxt = line_nxt;
    end else if (cmd.voice_emit) begin
      ov_nxt   = 1'b1;
      rd_nxt   = 8'd0;
      acc_nxt  = 1'b1;
      lo_nxt   = line_r;
      pv_nxt   = 1'b0;
      pb_nxt   = 8'd0;
      idx_nxt  = cmd.voice;
      last_nxt = (cmd.voice == LAST_VOICE);
      vol_nxt  = v_vol[3:0];
      if (v_vol[4]) begin
        vol_nxt = v_lvl;
        if (v_lvl != 4'd0 && shape_decays(regs_r[REG_ENV_SHAPE][3:0])) begin
          if (v_lvl < v_dec) begin
            decay_nxt[cmd.voice] = 4'd0;
            v_freq               = 17'd0;
          end else begin
            decay_nxt[cmd.voice] = v_lvl - v_dec;
          end
        end
      end
      nz_nxt   = v_noise;
      rate_nxt = v_noise ? {6'd0, regs_r[REG_NOISE], 3'd0} : v_freq;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= 8'd0;
      end
      for (int v = 0; v < NUM_VOICES; v++) begin
        decay_r[v] <= 4'd0;
      end
      sel_r  <= 4'd0;
      line_r <= 4'd0;
      ov_r   <= 1'b0;
    end else begin
      regs_r  <= regs_nxt;
      decay_r <= decay_nxt;
      sel_r   <= sel_nxt;
      line_r  <= line_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    acc_r  <= acc_nxt;
    lo_r   <= lo_nxt;
    pv_r   <= pv_nxt;
    pb_r   <= pb_nxt;
    idx_r  <= idx_nxt;
    rate_r <= rate_nxt;
    vol_r  <= vol_nxt;
    nz_r   <= nz_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = ov_r;
  assign out_read_data     = rd_r;
  assign out_accepted      = acc_r;
  assign out_line_outputs  = lo_r;
  assign out_printer_valid = pv_r;
  assign out_printer_byte  = pb_r;
  assign out_voice_index   = idx_r;
  assign out_voice_rate    = rate_r;
  assign out_voice_volume  = vol_r;
  assign out_voice_noise   = nz_r;
  assign out_last          = last_r;

endmodule

@@ tb/psg_checker.sv @@
// scoreboard for the psg register block: tracks register, select, decay and line state
// from accepted input words, predicts the output words and compares them in order
// depends on psgrv_pkg
module psg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_port,
  input  logic [7:0]  in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic        out_accepted,
  input  logic [3:0]  out_line_outputs,
  input  logic        out_printer_valid,
  input  logic [7:0]  out_printer_byte,
  input  logic [1:0]  out_voice_index,
  input  logic [16:0] out_voice_rate,
  input  logic [3:0]  out_voice_volume,
  input  logic        out_voice_noise,
  input  logic        out_last,
  output int          fail_count,
  output int          words_owed
);
  import psgrv_pkg::*;

  localparam logic [3:0] REG_AMP_A = 4'd8;
  // envelope shapes whose level runs down: 0-7, 9, 13 and 15
  localparam logic [15:0] DECAYING_SHAPES = 16'b1010_0010_1111_1111;
  localparam int ENV_FAST_BELOW = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        accepted;
    logic [3:0]  line_outputs;
    logic        printer_valid;
    logic [7:0]  printer_byte;
    logic [1:0]  voice_index;
    logic [16:0] voice_rate;
    logic [3:0]  voice_volume;
    logic        voice_noise;
    logic        last;
  } psg_word_t;

  logic [7:0] regs [16];
  logic [3:0] reg_sel;
  logic [3:0] decay [NUM_VOICES];
  logic [3:0] lines;
  psg_word_t  owed_words [$];

  initial begin
    fail_count = 0;
    words_owed = 0;
  end

  task automatic show_word(input string tag, input psg_word_t w);
    $display("  %s: rd=%0h acc=%0b lines=%0h prn=%0b/%0h voice=%0d rate=%0d vol=%0d noise=%0b last=%0b",
             tag, w.read_data, w.accepted, w.line_outputs, w.printer_valid, w.printer_byte,
             w.voice_index, w.voice_rate, w.voice_volume, w.voice_noise, w.last);
  endtask

  task automatic model_voice(input int v);
    psg_word_t   w;
    logic [11:0] period;
    logic [4:0]  amp;
    logic [3:0]  lvl;
    logic [3:0]  shape;
    logic [3:0]  dec;
    logic        tone_on;
    logic        noise_on;
    logic [16:0] rate;
    period   = {regs[2 * v + 1][3:0], regs[2 * v]};
    tone_on  = !regs[REG_MIXER][v];
    noise_on = !regs[REG_MIXER][3 + v];
    amp      = regs[REG_AMP_A + v][4:0];
    if ((!tone_on && !noise_on) || amp == 0 || period == 0) begin
      rate = '0;
    end else begin
      rate = TONE_CLOCK / {5'd0, period};
    end
    w = '0;
    w.voice_volume = amp[3:0];
    if (amp[4]) begin
      // envelope mode: report the level before this tick's drop
      lvl   = decay[v];
      shape = regs[REG_ENV_SHAPE][3:0];
      w.voice_volume = lvl;
      if (lvl != 0 && DECAYING_SHAPES[shape]) begin
        dec = (regs[REG_ENV_FINE] < ENV_FAST_BELOW) ? 4'd2 : 4'd1;
        if (lvl < dec) begin
          decay[v] = '0;
          rate = '0;
        end else begin
          decay[v] = lvl - dec;
        end
      end
    end
    w.accepted     = 1'b1;
    w.voice_index  = 2'(v);
    w.line_outputs = lines;
    w.voice_noise  = noise_on;
    w.voice_rate   = noise_on ? {6'd0, regs[REG_NOISE], 3'd0} : rate;
    w.last         = (2'(v) == LAST_VOICE);
    owed_words.push_back(w);
  endtask

  task automatic model_access(input logic [1:0] op, input logic [1:0] prt,
                              input logic [7:0] dat);
    psg_word_t  w;
    logic [7:0] changed;
    if (op == OP_TICK) begin
      for (int v = 0; v < NUM_VOICES; v++) model_voice(v);
    end else begin
      w = '0;
      w.last = 1'b1;
      if (op == OP_READ) begin
        w.read_data = regs[reg_sel];
        w.accepted  = 1'b1;
      end else if (op == OP_WRITE && prt == PORT_SEL) begin
        reg_sel    = dat[3:0];
        w.accepted = 1'b1;
      end else if (op == OP_WRITE && prt == PORT_DATA) begin
        w.accepted    = 1'b1;
        changed       = regs[reg_sel] ^ dat;
        regs[reg_sel] = dat;
        if (reg_sel == REG_ENV_SHAPE) begin
          for (int v = 0; v < NUM_VOICES; v++) decay[v] = DECAY_FULL;
        end
        if (reg_sel == REG_PORT_A && changed != 0) begin
          // strobe bit falling sends the other port's byte to the printer
          if (changed[5] && !dat[5]) begin
            w.printer_valid = 1'b1;
            w.printer_byte  = regs[REG_PORT_B];
          end
          lines = {dat[4], dat[3], ~dat[2], ~dat[0]};
        end
        if (reg_sel == REG_MIXER) begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            if (changed[v] && !dat[v]) decay[v] = DECAY_FULL;
          end
        end
      end
      w.line_outputs = lines;
      owed_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    psg_word_t seen;
    psg_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      for (int v = 0; v < NUM_VOICES; v++) decay[v] = '0;
      reg_sel = '0;
      lines   = '0;
      owed_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_read_data, out_accepted, out_line_outputs, out_printer_valid,
                out_printer_byte, out_voice_index, out_voice_rate, out_voice_volume,
                out_voice_noise, out_last};
        if (owed_words.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT) begin
            $display("psg_checker: output word with none expected");
            show_word("actual", seen);
          end
        end else begin
          want = owed_words.pop_front();
          if (seen !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= REPORT_LIMIT) begin
              $display("psg_checker: output word mismatch");
              show_word("expected", want);
              show_word("actual  ", seen);
            end
          end
        end
      end
      if (in_valid && in_ready) model_access(in_operation, in_port, in_data);
    end
    words_owed = owed_words.size();
  end

endmodule

@@ tb/tb_top.sv @@
// top of the psg register block testbench: clock, reset, stimulus and verdict
// instantiates psg_registers_and_voice_rates and psg_checker, uses psgrv_pkg
module tb_top;
  import psgrv_pkg::*;

  localparam logic [1:0] OP_UNKNOWN  = 2'd3;
  localparam logic [1:0] PORT_BAD_LO = 2'd1;
  localparam logic [1:0] PORT_BAD_HI = 2'd3;
  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_AMP_A = 4'd8;
  localparam logic [3:0] REG_AMP_B = 4'd9;
  localparam int PHASE_WORDS  = 34;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [1:0]  in_port = '0;
  logic [7:0]  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_accepted;
  logic [3:0]  out_line_outputs;
  logic        out_printer_valid;
  logic [7:0]  out_printer_byte;
  logic [1:0]  out_voice_index;
  logic [16:0] out_voice_rate;
  logic [3:0]  out_voice_volume;
  logic        out_voice_noise;
  logic        out_last;

  int fail_count;
  int words_owed;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;

  always #5 clk = ~clk;

  psg_registers_and_voice_rates u_top (.*);

  psg_checker u_checker (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // valid stays up between back-to-back words and only drops on an idle cycle
  task automatic send_word(input logic [1:0] op, input logic [1:0] prt,
                           input logic [7:0] dat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_port      <= prt;
    in_data      <= dat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [3:0] r, input logic [7:0] val);
    send_word(OP_WRITE, PORT_SEL, {4'($urandom), r});
    send_word(OP_WRITE, PORT_DATA, val);
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_word(OP_TICK, 2'($urandom), 8'($urandom));
  endtask

  task automatic random_sequence();
    int pick;
    logic [3:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 99) < 35) begin
        case ($urandom_range(0, 6))
          0: r = REG_MIXER;
          1: r = REG_ENV_SHAPE;
          2: r = REG_PORT_A;
          3: r = REG_PORT_B;
          4: r = REG_ENV_FINE;
          5: r = REG_NOISE;
          default: r = REG_AMP_A + 4'($urandom_range(0, 2));
        endcase
      end else begin
        r = 4'($urandom);
      end
      write_reg(r, 8'($urandom));
    end else if (pick < 65) begin
      tick_burst($urandom_range(1, 4));
    end else if (pick < 80) begin
      if ($urandom_range(0, 1)) send_word(OP_WRITE, PORT_SEL, 8'($urandom));
      send_word(OP_READ, 2'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      // envelope run of two to nine ticks, which can walk a level down to the clamp
      write_reg(REG_ENV_FINE, 8'($urandom_range(0, 15)));
      write_reg(REG_ENV_SHAPE, 8'($urandom));
      tick_burst($urandom_range(2, 9));
    end else begin
      send_word(2'($urandom), 2'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad ports and an unknown operation, printer strobe, lines, tone, noise and envelope
    send_word(OP_READ, PORT_BAD_HI, 8'hFF);
    send_word(OP_WRITE, PORT_BAD_LO, 8'hFF);
    send_word(OP_WRITE, PORT_BAD_HI, 8'h00);
    send_word(OP_UNKNOWN, PORT_DATA, 8'h5A);
    write_reg(REG_PORT_B, 8'hA5);
    write_reg(REG_PORT_A, 8'h3D);
    send_word(OP_WRITE, PORT_DATA, 8'h3D);
    send_word(OP_WRITE, PORT_DATA, 8'h00);
    write_reg(REG_NOISE, 8'hFF);
    write_reg(REG_TONE_A_FINE, 8'h01);
    write_reg(REG_TONE_A_COARSE, 8'hF0);
    write_reg(REG_TONE_B_FINE, 8'hFF);
    write_reg(REG_TONE_B_COARSE, 8'h0F);
    write_reg(REG_AMP_A, 8'h0F);
    write_reg(REG_AMP_B, 8'h1F);
    write_reg(REG_MIXER, 8'h34);
    write_reg(REG_ENV_SHAPE, 8'h00);
    tick_burst(1);
    send_word(OP_READ, PORT_SEL, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) random_sequence();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_owed == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/psgrv_pkg.sv
hdl/psgrv_ctrl.sv
hdl/psgrv_dp.sv
hdl/psg_registers_and_voice_rates.sv
tb/psg_checker.sv
tb/tb_top.sv
